// ===== sv/ufst_pkg.sv =====
// shared types and constants for the spanning-tree edge filter
`default_nettype none
package ufst_pkg;

  // node index width of the input words
  localparam int NODE_W = 8;
  // chosen-edge counter width
  localparam int COUNT_W = 8;
  // node count register width
  localparam int CFG_W = 9;
  // largest node count the index width can address
  localparam int NODE_LIMIT = 256;
  // node count after reset
  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 9'd256;

  // one edge word
  typedef struct packed {
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } in_t;

  // one result word
  typedef struct packed {
    logic               accepted;
    logic               tree_complete;
    logic [COUNT_W-1:0] chosen_total;
  } out_t;

endpackage
`default_nettype wire

// ===== sv/ufst_parent_ram.sv =====
// parent table memory: one read and one write port, registered read, per-entry valid bits
`default_nettype none
module ufst_parent_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [AW-1:0] wr_data,
  output logic      [AW-1:0] rd_data
);

  logic [AW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [AW-1:0]    rd_q_r;
  logic [AW-1:0]    rd_addr_r;
  logic             rd_hit_r;

  // storage array, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r    <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // valid bits: an entry never written reads as its own index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_hit_r ? rd_q_r : rd_addr_r;

endmodule
`default_nettype wire

// ===== sv/union_find_spanning_tree_edge_filter.sv =====
// spanning-tree edge filter: union-find with path halving over a parent table memory
// flow: accept reads node a; each halving step reads node then grandparent from the one read
//   port and rewrites the node's link; chain a, then chain b, then the root link and the result
//   register; words rejected at entry go straight to the result register
// throughput: one word at a time; the next word is taken once the result is in the output register
// reset: synchronous active-low; parent table reads as identity, count zero, node_count 256
`default_nettype none
module union_find_spanning_tree_edge_filter #(
  parameter int MAX_NODES = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire ufst_pkg::in_t               in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output ufst_pkg::out_t                   out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [ufst_pkg::CFG_W-1:0]  cfg_data
);

  localparam int CW    = ufst_pkg::CFG_W;
  localparam int NW    = ufst_pkg::COUNT_W;
  localparam int DEPTH = (MAX_NODES < ufst_pkg::NODE_LIMIT) ? MAX_NODES : ufst_pkg::NODE_LIMIT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [CW-1:0] DEPTH_N = CW'(DEPTH);
  localparam logic [CW-1:0] MIN_N   = CW'(2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT_X,
    ST_WAIT_P,
    ST_FINISH
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   node_count_r;
  logic [AW-1:0]   x_r, x_nxt;
  logic [AW-1:0]   b_r, b_nxt;
  logic [AW-1:0]   ra_r, ra_nxt;
  logic            sel_b_r, sel_b_nxt;
  logic            acc_r, acc_nxt;
  logic [NW-1:0]   chosen_r, chosen_nxt;
  logic            out_valid_r, out_valid_nxt;
  ufst_pkg::out_t  out_data_r, out_data_nxt;

  logic            rd_en, wr_en;
  logic [AW-1:0]   rd_addr, wr_addr, wr_data, rd_data;
  logic [CW-1:0]   eff_n, need;
  logic            in_ok, complete;

  // parent table
  ufst_parent_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_parent_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // effective node count clamped to the table and the edges it needs
  always_comb begin
    if (node_count_r < MIN_N) begin
      eff_n = MIN_N;
    end else if (node_count_r > DEPTH_N) begin
      eff_n = DEPTH_N;
    end else begin
      eff_n = node_count_r;
    end
  end
  assign need     = eff_n - CW'(1);
  assign complete = {1'b0, chosen_r} >= need;
  assign in_ok    = !complete && ({1'b0, in_data.node_a} < eff_n)
                    && ({1'b0, in_data.node_b} < eff_n);

  // no word or register write is taken while reset is held
  assign in_ready  = rst_n && (state_r == ST_IDLE);
  assign cfg_ready = rst_n;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // sequencer: walk chain a, then chain b, then link and report
  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    b_nxt         = b_r;
    ra_nxt        = ra_r;
    sel_b_nxt     = sel_b_r;
    acc_nxt       = acc_r;
    chosen_nxt    = chosen_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    rd_addr       = x_r;
    wr_en         = 1'b0;
    wr_addr       = x_r;
    wr_data       = rd_data;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          acc_nxt = 1'b0;
          if (in_ok) begin
            rd_en     = 1'b1;
            rd_addr   = in_data.node_a[AW-1:0];
            x_nxt     = in_data.node_a[AW-1:0];
            b_nxt     = in_data.node_b[AW-1:0];
            sel_b_nxt = 1'b0;
            state_nxt = ST_WAIT_X;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_WAIT_X: begin
        if (rd_data == x_r) begin
          // x is a root
          if (!sel_b_r) begin
            ra_nxt    = x_r;
            sel_b_nxt = 1'b1;
            x_nxt     = b_r;
            rd_en     = 1'b1;
            rd_addr   = b_r;
          end else begin
            if (ra_r != x_r) begin
              wr_en      = 1'b1;
              wr_addr    = ra_r;
              wr_data    = x_r;
              chosen_nxt = chosen_r + NW'(1);
              acc_nxt    = 1'b1;
            end
            state_nxt = ST_FINISH;
          end
        end else begin
          // fetch the grandparent
          rd_en     = 1'b1;
          rd_addr   = rd_data;
          state_nxt = ST_WAIT_P;
        end
      end
      ST_WAIT_P: begin
        // halve: x points at its grandparent and the walk moves there
        wr_en     = 1'b1;
        wr_addr   = x_r;
        wr_data   = rd_data;
        x_nxt     = rd_data;
        rd_en     = 1'b1;
        rd_addr   = rd_data;
        state_nxt = ST_WAIT_X;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.accepted      = acc_r;
          out_data_nxt.tree_complete = complete;
          out_data_nxt.chosen_total  = chosen_r;
          state_nxt                  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      node_count_r <= ufst_pkg::NODE_COUNT_RST;
      chosen_r     <= '0;
      out_valid_r  <= 1'b0;
      sel_b_r      <= 1'b0;
      acc_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chosen_r    <= chosen_nxt;
      out_valid_r <= out_valid_nxt;
      sel_b_r     <= sel_b_nxt;
      acc_r       <= acc_nxt;
      if (cfg_valid && cfg_ready) begin
        node_count_r <= cfg_data;
      end
    end
    x_r        <= x_nxt;
    b_r        <= b_nxt;
    ra_r       <= ra_nxt;
    out_data_r <= out_data_nxt;
  end

  // a read never targets the entry being written in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("parent table read and write hit the same entry");

  // the count only moves on an accepted edge
  a_count_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(chosen_r)) |-> (acc_r && state_r == ST_FINISH))
    else $error("chosen count changed without an accepted edge");

  // an accepted edge always reports a nonzero total
  a_accept_total: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.accepted) |-> (out_data.chosen_total != '0))
    else $error("accepted word with zero chosen total");

  // one word in flight: a taken edge blocks the input next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken twice in a row");

endmodule
`default_nettype wire

// ===== tb/sv/union_find_spanning_tree_edge_filter_test.sv =====
// self-checking testbench for the spanning-tree edge filter: table-driven and random edge words
module union_find_spanning_tree_edge_filter_test;

  localparam int CYCLE_LIMIT = 6_000_000;
  localparam int REPORT_LIMIT = 10;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER = 200;

  typedef logic [ufst_pkg::NODE_W-1:0]  node_t;
  typedef logic [ufst_pkg::COUNT_W-1:0] count_t;
  typedef logic [ufst_pkg::CFG_W-1:0]   setting_t;

  typedef enum logic {ROW_EDGE, ROW_NODES} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    node_t            a;
    node_t            b;
    setting_t         nodes;
    bit               pinned;
    ufst_pkg::out_t   want;
  } script_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  ufst_pkg::in_t    in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  ufst_pkg::out_t   out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  setting_t         cfg_data = '0;

  // typed-in expectation travelling with the offered word
  bit               in_pin = 1'b0;
  ufst_pkg::out_t   in_pin_word = '0;

  // shadow of the block: parent links, chosen count, node count register
  node_t            link_of [ufst_pkg::NODE_LIMIT];
  count_t           edges_chosen;
  setting_t         node_setting;

  ufst_pkg::out_t verdict_q [$];
  script_row_t    script [$];
  int unsigned    bad_count = 0;
  int unsigned    results_seen = 0;

  union_find_spanning_tree_edge_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // node count after clamping to the usable range
  function automatic int unsigned eff_nodes(input setting_t v);
    int unsigned n;
    n = 32'(v);
    if (n < 2) n = 2;
    if (n > ufst_pkg::NODE_LIMIT) n = ufst_pkg::NODE_LIMIT;
    return n;
  endfunction

  // root lookup with path halving, rewriting the shadow links as the block does
  function automatic node_t root_of(input node_t x);
    while (link_of[x] != x) begin
      link_of[x] = link_of[link_of[x]];
      x = link_of[x];
    end
    return x;
  endfunction

  // expected result of one edge word, updating the shadow state
  function automatic ufst_pkg::out_t judge_edge(input ufst_pkg::in_t w);
    int unsigned    n;
    int unsigned    need;
    node_t          ra;
    node_t          rb;
    ufst_pkg::out_t r;
    n = eff_nodes(node_setting);
    need = n - 1;
    r = '0;
    if (32'(edges_chosen) < need && 32'(w.node_a) < n && 32'(w.node_b) < n) begin
      ra = root_of(w.node_a);
      rb = root_of(w.node_b);
      if (ra != rb) begin
        link_of[ra] = rb;
        edges_chosen = edges_chosen + count_t'(1);
        r.accepted = 1'b1;
      end
    end
    r.tree_complete = (32'(edges_chosen) >= need);
    r.chosen_total = edges_chosen;
    return r;
  endfunction

  function automatic void add_edge(input int a, input int b, input bit pin,
                                   input int acc, input int done, input int total);
    script_row_t row;
    row.kind = ROW_EDGE;
    row.a = node_t'(a);
    row.b = node_t'(b);
    row.nodes = '0;
    row.pinned = pin;
    row.want.accepted = 1'(acc);
    row.want.tree_complete = 1'(done);
    row.want.chosen_total = count_t'(total);
    script.push_back(row);
  endfunction

  function automatic void add_nodes(input int v);
    script_row_t row;
    row = '{kind: ROW_NODES, a: '0, b: '0, nodes: setting_t'(v), pinned: 1'b0, want: '0};
    script.push_back(row);
  endfunction

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one edge word and hold it until taken
  task automatic offer_edge(input node_t a, input node_t b,
                            input bit pin, input ufst_pkg::out_t word, input int unsigned gap);
    in_valid <= 1'b1;
    in_data <= '{node_a: a, node_b: b};
    in_pin <= pin;
    in_pin_word <= word;
    do @(posedge clk); while (!in_ready);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and let every expected word come back
  // first wait for the clock so a word taken at this edge is already queued
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_nodes(input setting_t v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // result checking, shadow prediction on accepted words, register tracking
  always @(posedge clk) begin : result_watch
    ufst_pkg::out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          bad_count++;
          if (bad_count <= REPORT_LIMIT)
            $display("unexpected result word: acc=%0d done=%0d total=%0d",
                     out_data.accepted, out_data.tree_complete, out_data.chosen_total);
        end else begin
          want = verdict_q.pop_front();
          if (want.accepted !== out_data.accepted ||
              want.tree_complete !== out_data.tree_complete ||
              want.chosen_total !== out_data.chosen_total) begin
            bad_count++;
            if (bad_count <= REPORT_LIMIT)
              $display("result %0d mismatch: expected a=%0d d=%0d t=%0d, got a=%0d d=%0d t=%0d",
                       results_seen, want.accepted, want.tree_complete, want.chosen_total,
                       out_data.accepted, out_data.tree_complete, out_data.chosen_total);
          end
        end
      end
      if (in_valid && in_ready) begin
        want = judge_edge(in_data);
        verdict_q.push_back(in_pin ? in_pin_word : want);
      end
      if (cfg_valid && cfg_ready)
        node_setting = cfg_data;
    end
  end

  // receiver: runs of ready with stalls, and one long hold-off while words keep coming
  initial begin : result_sink
    int unsigned run;
    int unsigned stall;
    bit          held;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && results_seen >= HOLD_AFTER && in_valid) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // stimulus: reset, directed table, random phases at several node counts
  initial begin : edge_source
    int unsigned phase_nodes [9];
    int unsigned phase_words [9];
    int unsigned n;
    int unsigned fresh;
    int unsigned r;
    bit          steady;
    node_t       a;
    node_t       b;

    phase_nodes = '{16, 3, 40, 0, 100, 64, 180, 511, 256};
    phase_words = '{80, 10, 150, 10, 250, 60, 300, 250, 150};

    for (int i = 0; i < ufst_pkg::NODE_LIMIT; i++) link_of[i] = node_t'(i);
    edges_chosen = '0;
    node_setting = ufst_pkg::NODE_COUNT_RST;

    // self loops, extremes, clamped node counts, out-of-range endpoints, completion
    add_edge(0, 0, 1, 0, 0, 0);
    add_edge(0, 1, 1, 1, 0, 1);
    add_edge(1, 0, 1, 0, 0, 1);
    add_edge(255, 255, 1, 0, 0, 1);
    add_edge(255, 0, 1, 1, 0, 2);
    add_edge(0, 255, 1, 0, 0, 2);
    add_edge(170, 85, 1, 1, 0, 3);
    add_edge(85, 170, 1, 0, 0, 3);
    add_nodes(0);
    add_edge(0, 1, 1, 0, 1, 3);
    add_nodes(1);
    add_edge(2, 3, 1, 0, 1, 3);
    add_nodes(511);
    add_edge(3, 4, 1, 1, 0, 4);
    add_nodes(2);
    add_edge(5, 6, 1, 0, 1, 4);
    add_nodes(5);
    add_edge(5, 6, 1, 0, 1, 4);
    add_nodes(8);
    add_edge(8, 0, 1, 0, 0, 4);
    add_edge(0, 8, 1, 0, 0, 4);
    add_edge(2, 3, 0, 0, 0, 0);
    add_edge(5, 7, 0, 0, 0, 0);
    add_edge(7, 2, 0, 0, 0, 0);
    add_edge(6, 4, 1, 0, 1, 7);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_NODES) begin
        wait_idle();
        set_nodes(script[i].nodes);
      end else begin
        offer_edge(script[i].a, script[i].b, script[i].pinned, script[i].want, pick_gap());
      end
    end

    for (int p = 0; p < 9; p++) begin
      wait_idle();
      set_nodes(setting_t'(phase_nodes[p]));
      n = eff_nodes(setting_t'(phase_nodes[p]));
      steady = ($urandom_range(0, 2) == 0);
      fresh = $urandom_range(0, n - 1);
      repeat (phase_words[p]) begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          // join some node to the next fresh one
          a = node_t'($urandom_range(0, n - 1));
          b = node_t'(fresh);
          fresh = (fresh + 1) % n;
        end else if (r < 55) begin
          // consecutive links grow long parent chains
          a = node_t'((fresh + n - 1) % n);
          b = node_t'(fresh);
          fresh = (fresh + 1) % n;
        end else if (r < 90) begin
          a = node_t'($urandom_range(0, n - 1));
          b = node_t'($urandom_range(0, n - 1));
        end else if (r < 95) begin
          a = node_t'($urandom_range(0, n - 1));
          b = a;
        end else begin
          a = node_t'($urandom_range(0, 255));
          b = node_t'($urandom_range(0, 255));
        end
        offer_edge(a, b, 1'b0, '0, steady ? 0 : pick_gap());
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (bad_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
